// ----- hw/rtl/cfpad_pkg.sv -----
// Shared types, constants and AES round functions for the CAN frame pair decrypter.
// Depends on nothing; every other RTL file of the block imports it.
package cfpad_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 64;

  localparam logic [63:0] RESYNC_MAGIC = 64'hEFBEADDEBEBAFECA;
  localparam logic [28:0] CIPHER_ID_RESET = 29'h1000_0000;
  localparam logic [3:0] CAN_MAX_LEN = 4'd8;

  typedef enum logic [1:0] {
    REG_KEY_LOW = 2'd0,
    REG_KEY_HIGH = 2'd1,
    REG_CIPHER_ID_A = 2'd2,
    REG_CIPHER_ID_B = 2'd3
  } cfpad_reg_e;

  typedef enum logic {
    KIND_RESYNC = 1'b0,
    KIND_DECRYPT = 1'b1
  } cfpad_kind_e;

  // One unit of work for the back end. For a resync frame only blk[63:0] is used.
  typedef struct packed {
    cfpad_kind_e kind;
    logic [31:0] id;
    logic [3:0] len;
    logic [127:0] blk;
  } cfpad_job_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // Inverse of xtime, used to walk the round constant back down.
  function automatic logic [7:0] xtime_inv(input logic [7:0] a);
    xtime_inv = a[0] ? ({1'b0, a[7:1] ^ 7'h0d} | 8'h80) : {1'b0, a[7:1]};
  endfunction

  // RotWord, SubWord and the round constant applied to one little-endian word.
  function automatic logic [31:0] sub_rot(input logic [31:0] w, input logic [7:0] rc);
    sub_rot = {SBOX[w[7:0]], SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]] ^ rc};
  endfunction

  function automatic logic [127:0] key_step_fwd(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3;
    w0 = k[31:0] ^ sub_rot(k[127:96], rc);
    w1 = k[63:32] ^ w0;
    w2 = k[95:64] ^ w1;
    w3 = k[127:96] ^ w2;
    key_step_fwd = {w3, w2, w1, w0};
  endfunction

  function automatic logic [127:0] key_step_inv(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] p0, p1, p2, p3;
    p3 = k[127:96] ^ k[95:64];
    p2 = k[95:64] ^ k[63:32];
    p1 = k[63:32] ^ k[31:0];
    p0 = k[31:0] ^ sub_rot(p3, rc);
    key_step_inv = {p3, p2, p1, p0};
  endfunction

  // InvShiftRows followed by InvSubBytes.
  function automatic logic [127:0] inv_shift_sub(input logic [127:0] s);
    logic [127:0] t;
    logic [1:0] col;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int j = 0; j < 4; j++) begin
        col = 2'(c - j);
        t[8*(j+4*c) +: 8] = INV_SBOX[s[8*(j + 4*int'(col)) +: 8]];
      end
    end
    inv_shift_sub = t;
  endfunction

  function automatic logic [127:0] inv_mix(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0] a [4];
    logic [7:0] m9 [4];
    logic [7:0] m11 [4];
    logic [7:0] m13 [4];
    logic [7:0] m14 [4];
    logic [7:0] x2, x4, x8;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int j = 0; j < 4; j++) begin
        a[j] = s[8*(4*c+j) +: 8];
        x2 = xtime(a[j]);
        x4 = xtime(x2);
        x8 = xtime(x4);
        m9[j] = x8 ^ a[j];
        m11[j] = x8 ^ x2 ^ a[j];
        m13[j] = x8 ^ x4 ^ a[j];
        m14[j] = x8 ^ x4 ^ x2;
      end
      t[8*(4*c) +: 8] = m14[0] ^ m11[1] ^ m13[2] ^ m9[3];
      t[8*(4*c+1) +: 8] = m9[0] ^ m14[1] ^ m11[2] ^ m13[3];
      t[8*(4*c+2) +: 8] = m13[0] ^ m9[1] ^ m14[2] ^ m11[3];
      t[8*(4*c+3) +: 8] = m11[0] ^ m13[1] ^ m9[2] ^ m14[3];
    end
    inv_mix = t;
  endfunction

endpackage

// ----- hw/rtl/cfpad_fifo.sv -----
// Short job queue that decouples the frame classifier from the AES back end.
// Depends on cfpad_pkg for the job type.
module cfpad_fifo import cfpad_pkg::*; #(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  cfpad_job_t wdata_i,
  input  logic       pop_i,
  output cfpad_job_t rdata_o,
  output logic       full_o,
  output logic       empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cfpad_job_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic do_push, do_pop;

  assign full_o = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    cnt_d = cnt_q + CntW'(do_push) - CntW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ----- hw/rtl/cfpad_front.sv -----
// Front end: classifies received frames, pairs cipher halves and queues jobs.
// Depends on cfpad_pkg for the job type and the resync magic.
module cfpad_front import cfpad_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic [31:0] frame_id_i,
  input  logic [3:0]  frame_len_i,
  input  logic [63:0] frame_data_i,
  input  logic [28:0] cipher_id_a_i,
  input  logic [28:0] cipher_id_b_i,
  output logic        job_push_o,
  output cfpad_job_t  job_o
);

  logic [63:0] held_q;
  logic phase_q, phase_d;
  logic is_magic, is_cipher;

  assign is_magic = (frame_data_i == RESYNC_MAGIC);
  assign is_cipher = (frame_len_i == CAN_MAX_LEN) &&
                     ((frame_id_i[28:0] == cipher_id_a_i) ||
                      (frame_id_i[28:0] == cipher_id_b_i));

  always_comb begin
    phase_d = phase_q;
    job_push_o = 1'b0;
    job_o.kind = KIND_RESYNC;
    job_o.id = frame_id_i;
    job_o.len = frame_len_i;
    job_o.blk = {frame_data_i, held_q};
    if (accept_i) begin
      if (is_magic) begin
        phase_d = 1'b0;
        job_push_o = 1'b1;
        job_o.blk = {64'd0, frame_data_i};
      end else if (is_cipher) begin
        phase_d = !phase_q;
        if (phase_q) begin
          job_push_o = 1'b1;
          job_o.kind = KIND_DECRYPT;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 1'b0;
      held_q <= '0;
    end else begin
      phase_q <= phase_d;
      if (accept_i && !is_magic && is_cipher && !phase_q) begin
        held_q <= frame_data_i;
      end
    end
  end

endmodule

// ----- hw/rtl/cfpad_back.sv -----
// Back end: iterative AES-128 decryption of queued blocks and the result register.
// Depends on cfpad_pkg for the job type and the AES round functions.
module cfpad_back import cfpad_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         job_empty_i,
  input  cfpad_job_t   job_i,
  output logic         job_pop_o,
  input  logic [127:0] key_i,
  input  logic         res_pop_i,
  output logic         res_valid_o,
  output logic         res_kind_o,
  output logic [31:0]  res_id_o,
  output logic [3:0]   res_len_o,
  output logic [63:0]  res_data_o
);

  typedef enum logic [1:0] {
    StIdle,
    StKeyExp,
    StRound,
    StFinish
  } state_e;

  state_e state_q;
  logic [127:0] s_q, k_q, k_fwd, k_inv, st_round;
  logic [7:0] rc_q, rc_use;
  logic [3:0] cnt_q;
  logic res_free;
  logic [7:0] pt_len_byte;
  logic [3:0] pt_len;
  logic [31:0] pt_id;
  logic [63:0] pt_data;

  assign res_free = !res_valid_o || res_pop_i;
  assign job_pop_o = (state_q == StIdle) && !job_empty_i &&
                     ((job_i.kind == KIND_DECRYPT) || res_free);

  assign rc_use = xtime_inv(rc_q);
  assign k_fwd = key_step_fwd(k_q, rc_q);
  assign k_inv = key_step_inv(k_q, rc_use);
  assign st_round = inv_shift_sub(s_q) ^ k_inv;

  // Plaintext byte 2 flags an extended id, bytes 3..6 carry it, byte 7 the length.
  always_comb begin
    pt_len_byte = s_q[63:56];
    pt_len = (pt_len_byte > 8'(CAN_MAX_LEN)) ? CAN_MAX_LEN : pt_len_byte[3:0];
    pt_id = s_q[55:24] | {(s_q[23:16] != 8'd0), 31'd0};
    for (int i = 0; i < 8; i++) begin
      pt_data[8*i +: 8] = (4'(i) < pt_len) ? s_q[64 + 8*i +: 8] : 8'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      res_valid_o <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (res_pop_i) begin
        res_valid_o <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (job_pop_o) begin
            if (job_i.kind == KIND_RESYNC) begin
              res_valid_o <= 1'b1;
              res_kind_o <= KIND_RESYNC;
              res_id_o <= job_i.id;
              res_len_o <= job_i.len;
              res_data_o <= job_i.blk[63:0];
            end else begin
              s_q <= job_i.blk;
              k_q <= key_i;
              rc_q <= 8'h01;
              cnt_q <= '0;
              state_q <= StKeyExp;
            end
          end
        end
        StKeyExp: begin
          k_q <= k_fwd;
          rc_q <= xtime(rc_q);
          if (cnt_q == 4'd9) begin
            s_q <= s_q ^ k_fwd;
            state_q <= StRound;
          end else begin
            cnt_q <= cnt_q + 4'd1;
          end
        end
        StRound: begin
          k_q <= k_inv;
          rc_q <= rc_use;
          if (cnt_q == 4'd0) begin
            s_q <= st_round;
            state_q <= StFinish;
          end else begin
            s_q <= inv_mix(st_round);
            cnt_q <= cnt_q - 4'd1;
          end
        end
        StFinish: begin
          if (res_free) begin
            res_valid_o <= 1'b1;
            res_kind_o <= KIND_DECRYPT;
            res_id_o <= pt_id;
            res_len_o <= pt_len;
            res_data_o <= pt_data;
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

// ----- hw/rtl/can_frame_pair_aes_decrypter_top.sv -----
// CAN frame pair decrypter: a resync frame goes straight into the result register when the
// back end takes it; a cipher pair yields its frame once the second half is accepted,
// after 10 key expansion steps plus 10 inverse rounds of one shared round unit.
// The back end decrypts one pair at a time and takes no new job until its result is registered.
// Reset is asynchronous and active low: queues empty, pairing phase and held half clear,
// key zero and both cipher ids 0x10000000.
// Depends on cfpad_pkg, cfpad_front, cfpad_fifo and cfpad_back.
module can_frame_pair_aes_decrypter_top import cfpad_pkg::*; #(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              push,
  output logic              full,
  input  logic [31:0]       frame_id_i,
  input  logic [3:0]        frame_len_i,
  input  logic [63:0]       frame_data_i,
  output logic              empty,
  input  logic              pop,
  output logic              out_kind_o,
  output logic [31:0]       out_id_o,
  output logic [3:0]        out_len_o,
  output logic [63:0]       out_data_o
);

  // Configuration registers. Each register occupies an eight byte slot, so the
  // register index is simply the upper address bits.
  logic [63:0] key_low_q, key_high_q;
  logic [28:0] id_a_q, id_b_q;
  cfpad_reg_e reg_sel;
  logic cfg_wr;

  assign pready = 1'b1;
  assign reg_sel = cfpad_reg_e'(paddr[4:3]);
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q <= '0;
      key_high_q <= '0;
      id_a_q <= CIPHER_ID_RESET;
      id_b_q <= CIPHER_ID_RESET;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_KEY_LOW: key_low_q <= pwdata;
        REG_KEY_HIGH: key_high_q <= pwdata;
        REG_CIPHER_ID_A: id_a_q <= pwdata[28:0];
        REG_CIPHER_ID_B: id_b_q <= pwdata[28:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_KEY_LOW: prdata = key_low_q;
      REG_KEY_HIGH: prdata = key_high_q;
      REG_CIPHER_ID_A: prdata = {35'd0, id_a_q};
      REG_CIPHER_ID_B: prdata = {35'd0, id_b_q};
      default: prdata = '0;
    endcase
  end

  // The front end takes a frame whenever the job queue has room. Frames that make
  // no job (dropped frames and first halves) are still taken as a transaction.
  logic accept, job_push, job_pop, job_full, job_empty;
  cfpad_job_t job_in, job_out;

  assign full = job_full;
  assign accept = push && !job_full;

  cfpad_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .frame_id_i    (frame_id_i),
    .frame_len_i   (frame_len_i),
    .frame_data_i  (frame_data_i),
    .cipher_id_a_i (id_a_q),
    .cipher_id_b_i (id_b_q),
    .job_push_o    (job_push),
    .job_o         (job_in)
  );

  cfpad_fifo #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .wdata_i (job_in),
    .pop_i   (job_pop),
    .rdata_o (job_out),
    .full_o  (job_full),
    .empty_o (job_empty)
  );

  // The back end holds one finished result; it keeps decrypting the next pair while that
  // result waits to be popped, but takes a resync job only once the result is free.
  logic res_valid;

  cfpad_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_empty_i (job_empty),
    .job_i       (job_out),
    .job_pop_o   (job_pop),
    .key_i       ({key_high_q, key_low_q}),
    .res_pop_i   (pop && res_valid),
    .res_valid_o (res_valid),
    .res_kind_o  (out_kind_o),
    .res_id_o    (out_id_o),
    .res_len_o   (out_len_o),
    .res_data_o  (out_data_o)
  );

  assign empty = !res_valid;

endmodule

// ----- hw/rtl/cfpad_checker.sv -----
// Port-level checker for the CAN frame pair decrypter, bound to the top level.
// Depends on cfpad_pkg for the length limit.
module cfpad_checker import cfpad_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              empty,
  input logic              pop,
  input logic              out_kind_o,
  input logic [31:0]       out_id_o,
  input logic [3:0]        out_len_o,
  input logic [63:0]       out_data_o
);

  // A waiting result stays until it is popped.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty)
    else $error("result withdrawn before pop");

  // A waiting result keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> $stable(out_data_o) && $stable(out_id_o) && $stable(out_kind_o) &&
                       $stable(out_len_o))
    else $error("result payload changed while stalled");

  // Decrypted frames never carry more than eight data bytes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && out_kind_o |-> out_len_o <= CAN_MAX_LEN)
    else $error("decrypted length exceeds eight");

  // Bytes of a decrypted frame beyond its length are zero; check the top byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && out_kind_o && out_len_o != CAN_MAX_LEN |-> out_data_o[63:56] == 8'd0)
    else $error("unused data byte not cleared");

endmodule

bind can_frame_pair_aes_decrypter_top cfpad_checker u_checker (.*);

// ----- tb/can_frame_pair_aes_decrypter_top_tb.sv -----
// Self-checking testbench for the CAN frame pair decrypter (resync forwarding, cipher-pair
// AES-128 decryption, APB key and identifier registers), with its own AES predictor.
// Depends on cfpad_pkg and can_frame_pair_aes_decrypter_top.
module can_frame_pair_aes_decrypter_top_tb;
  import cfpad_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [28:0] ID_ALL_ONES = 29'h1FFF_FFFF;
  localparam int SETTLE_CYCLES = 40;

  // One decoded frame as the block should emit it.
  typedef struct {
    cfpad_kind_e kind;
    logic [31:0] id;
    logic [3:0]  len;
    logic [63:0] data;
  } frame_t;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              push;
  logic              full;
  logic [31:0]       frame_id_i;
  logic [3:0]        frame_len_i;
  logic [63:0]       frame_data_i;
  logic              empty;
  logic              pop;
  logic              out_kind_o;
  logic [31:0]       out_id_o;
  logic [3:0]        out_len_o;
  logic [63:0]       out_data_o;

  can_frame_pair_aes_decrypter_top DUT (.*);

  // Predictor copy of the registers and the pairing state.
  logic [63:0] key_lo_q, key_hi_q;
  logic [28:0] id_a_q, id_b_q;
  logic [63:0] held_half_q;
  logic        second_half_q;

  frame_t pending_frames[$];
  logic [7:0] sub_box[256];
  logic [7:0] inv_box[256];

  int errors;
  int frames_sent;
  int frames_checked;
  int send_idle_pct;
  int pop_stall_pct;
  int hold_left;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
    logic [7:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return r;
  endfunction

  // The S-box is derived from the field inverse and the affine map, not copied.
  function automatic void build_boxes();
    logic [7:0] b, s;
    for (int x = 0; x < 256; x++) begin
      b = '0;
      for (int y = 1; y < 256; y++) begin
        if (gf_mul(8'(x), 8'(y)) == 8'h01) b = 8'(y);
      end
      s = b ^ {b[6:0], b[7]} ^ {b[5:0], b[7:6]} ^ {b[4:0], b[7:5]} ^ {b[3:0], b[7:4]} ^ 8'h63;
      sub_box[x] = s;
      inv_box[s] = 8'(x);
    end
  endfunction

  // AES-128 decryption of one block; byte i of key, block and result sits in bits 8i+7:8i.
  function automatic logic [127:0] aes128_decrypt(logic [127:0] key, logic [127:0] blk);
    logic [7:0] rk[176];
    logic [7:0] s[16];
    logic [7:0] t[16];
    logic [7:0] tmp[4];
    logic [7:0] rc, f, a0, a1, a2, a3;
    logic [127:0] res;
    rc = 8'h01;
    for (int i = 0; i < 16; i++) rk[i] = key[8*i +: 8];
    for (int i = 16; i < 176; i += 4) begin
      for (int j = 0; j < 4; j++) tmp[j] = rk[i-4+j];
      if (i % 16 == 0) begin
        f = tmp[0];
        tmp[0] = sub_box[tmp[1]] ^ rc;
        tmp[1] = sub_box[tmp[2]];
        tmp[2] = sub_box[tmp[3]];
        tmp[3] = sub_box[f];
        rc = gf_mul(rc, 8'h02);
      end
      for (int j = 0; j < 4; j++) rk[i+j] = rk[i-16+j] ^ tmp[j];
    end
    for (int i = 0; i < 16; i++) s[i] = blk[8*i +: 8] ^ rk[160+i];
    for (int r = 9; r >= 0; r--) begin
      for (int c = 0; c < 4; c++) begin
        for (int j = 0; j < 4; j++) t[j+4*c] = inv_box[s[j + 4*((c-j) & 3)]];
      end
      for (int i = 0; i < 16; i++) s[i] = t[i] ^ rk[16*r+i];
      if (r > 0) begin
        for (int c = 0; c < 4; c++) begin
          a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
          s[4*c]   = gf_mul(a0, 8'd14) ^ gf_mul(a1, 8'd11) ^ gf_mul(a2, 8'd13) ^
                     gf_mul(a3, 8'd9);
          s[4*c+1] = gf_mul(a0, 8'd9) ^ gf_mul(a1, 8'd14) ^ gf_mul(a2, 8'd11) ^
                     gf_mul(a3, 8'd13);
          s[4*c+2] = gf_mul(a0, 8'd13) ^ gf_mul(a1, 8'd9) ^ gf_mul(a2, 8'd14) ^
                     gf_mul(a3, 8'd11);
          s[4*c+3] = gf_mul(a0, 8'd11) ^ gf_mul(a1, 8'd13) ^ gf_mul(a2, 8'd9) ^
                     gf_mul(a3, 8'd14);
        end
      end
    end
    for (int i = 0; i < 16; i++) res[8*i +: 8] = s[i];
    return res;
  endfunction

  // Advances the pairing state by one accepted frame and queues the frame it yields, if any.
  function automatic void predict_frame(logic [31:0] id, logic [3:0] len, logic [63:0] data);
    frame_t f;
    logic [127:0] pt;
    if (data == RESYNC_MAGIC) begin
      second_half_q = 1'b0;
      f.kind = KIND_RESYNC;
      f.id = id;
      f.len = len;
      f.data = data;
      pending_frames.push_back(f);
      return;
    end
    if (len != CAN_MAX_LEN || (id[28:0] != id_a_q && id[28:0] != id_b_q)) return;
    if (!second_half_q) begin
      held_half_q = data;
      second_half_q = 1'b1;
      return;
    end
    second_half_q = 1'b0;
    pt = aes128_decrypt({key_hi_q, key_lo_q}, {data, held_half_q});
    f.kind = KIND_DECRYPT;
    f.id = pt[55:24];
    if (pt[23:16] != 8'h00) f.id[31] = 1'b1;
    f.len = (pt[63:56] > 8'd8) ? CAN_MAX_LEN : pt[59:56];
    f.data = '0;
    for (int i = 0; i < 8; i++) begin
      if (i < f.len) f.data[8*i +: 8] = pt[64+8*i +: 8];
    end
    pending_frames.push_back(f);
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // The checker samples every popped transaction at the rising edge.
  always @(posedge clk_i) begin
    frame_t w;
    if (rst_ni && pop && !empty) begin
      if (pending_frames.size() == 0) begin
        report_mismatch("unexpected frame id", 64'(out_id_o), '0);
      end else begin
        w = pending_frames.pop_front();
        frames_checked++;
        if (out_kind_o !== w.kind) report_mismatch("out_kind", 64'(out_kind_o), 64'(w.kind));
        if (out_id_o !== w.id) report_mismatch("out_id", 64'(out_id_o), 64'(w.id));
        if (out_len_o !== w.len) report_mismatch("out_len", 64'(out_len_o), 64'(w.len));
        if (out_data_o !== w.data) report_mismatch("out_data", out_data_o, w.data);
      end
    end
  end

  // The receiver stalls at random, and all the time while a long hold-off is counting down.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= pop_stall_pct);
    end
  end

  // Sends one frame; push stays high after acceptance so back-to-back transactions work.
  task automatic send_frame(logic [31:0] id, logic [3:0] len, logic [63:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      push <= 1'b0;
    end
    @(negedge clk_i);
    push <= 1'b1;
    frame_id_i <= id;
    frame_len_i <= len;
    frame_data_i <= data;
    do @(posedge clk_i); while (full);
    predict_frame(id, len, data);
    frames_sent++;
  endtask

  // Lowers push and lets every outstanding frame drain before a register write.
  task automatic drain();
    @(negedge clk_i);
    push <= 1'b0;
    wait (pending_frames.size() == 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(cfpad_reg_e idx, logic [63:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(8 * int'(idx));
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_KEY_LOW: key_lo_q = value;
      REG_KEY_HIGH: key_hi_q = value;
      REG_CIPHER_ID_A: id_a_q = value[28:0];
      default: id_b_q = value[28:0];
    endcase
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_config(logic [63:0] klo, logic [63:0] khi, logic [63:0] ida,
                            logic [63:0] idb);
    drain();
    write_reg(REG_KEY_LOW, klo);
    write_reg(REG_KEY_HIGH, khi);
    write_reg(REG_CIPHER_ID_A, ida);
    write_reg(REG_CIPHER_ID_B, idb);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [31:0] cipher_word(logic use_b);
    return {$urandom_range(7) == 0 ? 3'($urandom) : 3'b000, use_b ? id_b_q : id_a_q};
  endfunction

  // Extremes of every field, both cipher ids, the resync magic and the dropped cases.
  task automatic test_directed();
    send_idle_pct = 0;
    pop_stall_pct = 0;
    // Reset values: both ids 0x10000000 and a zero key.
    send_frame({3'b000, CIPHER_ID_RESET}, 4'd8, 64'h0);
    send_frame({3'b000, CIPHER_ID_RESET}, 4'd8, '1);
    set_config(64'h0706050403020100, 64'h0f0e0d0c0b0a0908, '0, {35'h0, ID_ALL_ONES});
    // Magic frames pass whatever their id and length code.
    send_frame('1, 4'd15, RESYNC_MAGIC);
    send_frame('0, 4'd0, RESYNC_MAGIC);
    // A matching id with a wrong length code is dropped.
    send_frame('0, 4'd7, rand64());
    send_frame({3'b000, ID_ALL_ONES}, 4'd15, rand64());
    send_frame({3'b000, ID_ALL_ONES}, 4'd0, rand64());
    // Flag bits are ignored by the id match; pair across both ids.
    send_frame(32'hE000_0000, 4'd8, '1);
    send_frame('1, 4'd8, '0);
    // A resync between the halves restarts the pairing.
    send_frame('0, 4'd8, rand64());
    send_frame(32'h1234_5678, 4'd3, RESYNC_MAGIC);
    send_frame('0, 4'd8, rand64());
    send_frame('0, 4'd8, rand64());
    // Frames with an unmatched id are dropped even mid-pair.
    send_frame('0, 4'd8, rand64());
    send_frame(32'h0000_0001, 4'd8, rand64());
    send_frame('1, 4'd8, rand64());
    set_config('1, '1, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_E000_0005);
    for (int i = 0; i < 4; i++) send_frame(cipher_word(i[0]), 4'd8, rand64());
  endtask

  // Mostly well-formed pairs with random content, some resyncs and some noise.
  task automatic test_random(int count, int idle_pct, int stall_pct);
    int pick;
    send_idle_pct = idle_pct;
    pop_stall_pct = stall_pct;
    set_config(rand64(), rand64(), rand64(), $urandom_range(1) ? rand64() : {35'h0, id_a_q});
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 75) send_frame(cipher_word(1'($urandom_range(1))), 4'd8, rand64());
      else if (pick < 85) send_frame($urandom, 4'($urandom), RESYNC_MAGIC);
      else send_frame($urandom, 4'($urandom), rand64());
    end
  endtask

  // The receiver holds off long enough for the block to fill up and stall its input.
  task automatic test_backpressure();
    send_idle_pct = 0;
    pop_stall_pct = 0;
    drain();
    @(negedge clk_i);
    hold_left <= 300;
    for (int i = 0; i < 24; i++) begin
      if (i % 3 == 0) send_frame($urandom, 4'($urandom), RESYNC_MAGIC);
      else send_frame(cipher_word(i[0]), 4'd8, rand64());
    end
  endtask

  initial begin
    errors = 0;
    frames_sent = 0;
    frames_checked = 0;
    send_idle_pct = 0;
    pop_stall_pct = 0;
    hold_left = 0;
    key_lo_q = '0;
    key_hi_q = '0;
    id_a_q = CIPHER_ID_RESET;
    id_b_q = CIPHER_ID_RESET;
    held_half_q = '0;
    second_half_q = 1'b0;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    push = 1'b0;
    pop = 1'b0;
    frame_id_i = '0;
    frame_len_i = '0;
    frame_data_i = '0;
    build_boxes();
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_random(160, 0, 0);
    test_random(160, 46, 0);
    test_random(160, 0, 46);
    test_random(160, 31, 31);
    test_backpressure();
    test_random(40, 0, 0);
    // The last settings keep the zero key and equal ids covered too.
    set_config('0, '0, {35'h0, ID_ALL_ONES}, {35'h0, ID_ALL_ONES});
    test_random(20, 20, 20);

    drain();
    $display("Sent %0d frames and checked %0d output frames over several key, id and",
             frames_sent, frames_checked);
    $display("idling settings, including a long receiver hold-off; %0d mismatches.", errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Timeout with %0d frames still expected.", pending_frames.size());
    $display("FAIL");
    $finish;
  end

endmodule
